/* rtl/core/bprq_pkg.sv */
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared types, constants and helpers for the bitmap priority ready queue.
// ----------------------------------------------------------------------------
package bprq_pkg;

  // Field widths of the request and response beats.
  localparam int PRIO_W = 6;
  localparam int TASK_W = 6;

  // A priority splits into a row (upper bits) and a bit within the row.
  localparam int         ROW_SHIFT = 3;
  localparam logic [2:0] ROW_MASK  = 3'h7;
  localparam int         NUM_ROWS  = 8;

  // Operation codes carried in the kind field.
  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_op;   // capture the request and read head and tail
    logic exec;      // apply the add, or start the remove
    logic pop;       // advance the chain head to the successor
    logic load_out;  // load the response register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_pop;  // the remove leaves a successor at the head
  } dp_status_t;

  // Index of the lowest set bit of a byte; zero for an empty byte.
  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

/* rtl/core/bprq_ctrl.sv */
// ----------------------------------------------------------------------------
// bprq_ctrl
// Sequencer that steps one request through lookup, update and response.
// ----------------------------------------------------------------------------
module bprq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output bprq_pkg::dp_cmd_t     cmd,
  input  bprq_pkg::dp_status_t  status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  // The response register can take a new beat when empty or being drained.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Commands follow directly from the state.
  always_comb begin
    cmd          = '0;
    cmd.load_op  = (state == S_IDLE) && req_valid;
    cmd.exec     = (state == S_EXEC);
    cmd.pop      = (state == S_POP);
    cmd.load_out = (state == S_FIN) && out_free;
  end

  // State and the response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // The flag rises when the register loads and falls once the beat drains.
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= status.need_pop ? S_POP : S_FIN;
        end
        S_POP: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/bprq_datapath.sv */
// ----------------------------------------------------------------------------
// bprq_datapath
// Ready bitmaps, chain memories, successor links and the response register.
// ----------------------------------------------------------------------------
module bprq_datapath #(
  parameter int NUM_PRIOS    = 64,
  parameter int NUM_TASK_IDS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bprq_pkg::dp_cmd_t             cmd,
  output bprq_pkg::dp_status_t          status,
  input  logic                          kind,
  input  logic [bprq_pkg::PRIO_W-1:0]   prio,
  input  logic [bprq_pkg::TASK_W-1:0]   task_req,
  output logic [bprq_pkg::TASK_W-1:0]   removed_task,
  output logic                          removed_valid,
  output logic [bprq_pkg::PRIO_W-1:0]   highest_ready,
  output logic                          any_ready
);

  // Task ids above the field range never arrive, so storage stops there.
  localparam int TASK_SPAN  = 2 ** bprq_pkg::TASK_W;
  localparam int TASK_DEPTH = (NUM_TASK_IDS < TASK_SPAN) ? NUM_TASK_IDS : TASK_SPAN;
  localparam int PIDX_W     = $clog2(NUM_PRIOS);
  localparam int TIDX_W     = $clog2(TASK_DEPTH);
  localparam logic [bprq_pkg::PRIO_W:0] PRIO_LIMIT = (bprq_pkg::PRIO_W + 1)'(NUM_PRIOS);
  localparam logic [8:0]                TASK_LIMIT = 9'(NUM_TASK_IDS);

  // Captured request and registered memory read data.
  logic                        kind_q;
  logic [bprq_pkg::PRIO_W-1:0] prio_q;
  logic [bprq_pkg::TASK_W-1:0] task_q;
  logic [bprq_pkg::TASK_W-1:0] head_q;
  logic [bprq_pkg::TASK_W-1:0] tail_q;
  logic [bprq_pkg::TASK_W-1:0] succ_q;
  logic [bprq_pkg::TASK_W-1:0] rem_task_q;
  logic                        rem_ok_q;

  // Ready bitmaps and successor valid marks.
  logic [7:0]            group_bits;
  logic [7:0]            row_bits [bprq_pkg::NUM_ROWS];
  logic [TASK_DEPTH-1:0] succ_valid;

  // Chain memories and successor ids.
  logic [bprq_pkg::TASK_W-1:0] chain_head [NUM_PRIOS];
  logic [bprq_pkg::TASK_W-1:0] chain_tail [NUM_PRIOS];
  logic [bprq_pkg::TASK_W-1:0] succ_id    [TASK_DEPTH];

  logic              prio_ok, task_ok, head_ok, tail_ok;
  logic [2:0]        row_sel, bit_sel;
  logic [7:0]        row_clr;
  logic              live, is_rem, has_succ, do_add, do_last;
  logic [PIDX_W-1:0] p_idx, p_idx_in;
  logic [TIDX_W-1:0] h_idx, t_idx, k_idx;
  logic              head_we;
  logic [bprq_pkg::TASK_W-1:0] head_wd;
  logic [2:0]        grp_low, row_low;

  // Range checks and addressing of the captured request.
  assign prio_ok  = {1'b0, prio_q} < PRIO_LIMIT;
  assign task_ok  = {3'b0, task_q} < TASK_LIMIT;
  assign head_ok  = {3'b0, head_q} < TASK_LIMIT;
  assign tail_ok  = {3'b0, tail_q} < TASK_LIMIT;
  assign row_sel  = prio_q[bprq_pkg::PRIO_W-1:bprq_pkg::ROW_SHIFT];
  assign bit_sel  = prio_q[2:0] & bprq_pkg::ROW_MASK;
  assign p_idx    = prio_q[PIDX_W-1:0];
  assign p_idx_in = prio[PIDX_W-1:0];
  assign h_idx    = head_q[TIDX_W-1:0];
  assign t_idx    = tail_q[TIDX_W-1:0];
  assign k_idx    = task_q[TIDX_W-1:0];

  // Decide what the operation does to the chains and bitmaps.
  assign live     = prio_ok && row_bits[row_sel][bit_sel];
  assign is_rem   = (kind_q == bprq_pkg::KIND_REMOVE);
  assign has_succ = head_ok && succ_valid[h_idx];
  assign do_add   = cmd.exec && !is_rem && prio_ok && task_ok;
  assign do_last  = cmd.exec && is_rem && live && !has_succ;
  assign row_clr  = row_bits[row_sel] & ~(8'b1 << bit_sel);

  assign status.need_pop = is_rem && live && has_succ;

  // The head is written by an add to an empty level or by a pop.
  assign head_we = (do_add && !live) || cmd.pop;
  assign head_wd = cmd.pop ? succ_q : task_q;

  // Capture the request and read its head and tail.
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      kind_q <= kind;
      prio_q <= prio;
      task_q <= task_req;
      head_q <= chain_head[p_idx_in];
      tail_q <= chain_tail[p_idx_in];
    end
  end

  // Chain head memory.
  always_ff @(posedge clk) begin
    if (head_we) begin
      chain_head[p_idx] <= head_wd;
    end
  end

  // Chain tail memory.
  always_ff @(posedge clk) begin
    if (do_add) begin
      chain_tail[p_idx] <= task_q;
    end
  end

  // Successor id memory: link the old tail on an add, look up on a remove.
  always_ff @(posedge clk) begin
    if (do_add && live && tail_ok) begin
      succ_id[t_idx] <= task_q;
    end
    if (cmd.exec) begin
      succ_q <= succ_id[h_idx];
    end
  end

  // Successor valid marks; the added task always ends its chain, so an old
  // tail that is the added task itself stays unlinked.
  always_ff @(posedge clk) begin
    if (rst) begin
      succ_valid <= '0;
    end else begin
      if (do_add) begin
        if (live && tail_ok && (t_idx != k_idx)) begin
          succ_valid[t_idx] <= 1'b1;
        end
        succ_valid[k_idx] <= 1'b0;
      end
      if (cmd.pop) begin
        succ_valid[h_idx] <= 1'b0;
      end
    end
  end

  // Row and group bitmaps.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits <= '0;
      for (int i = 0; i < bprq_pkg::NUM_ROWS; i++) begin
        row_bits[i] <= '0;
      end
    end else if (do_add) begin
      row_bits[row_sel]   <= row_bits[row_sel] | (8'b1 << bit_sel);
      group_bits[row_sel] <= 1'b1;
    end else if (do_last) begin
      row_bits[row_sel] <= row_clr;
      if (row_clr == 8'b0) begin
        group_bits[row_sel] <= 1'b0;
      end
    end
  end

  // Remember what a remove popped.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rem_ok_q   <= is_rem && live;
      rem_task_q <= (is_rem && live) ? head_q : '0;
    end
  end

  // Two-level lowest-set-bit encode of the bitmaps.
  assign grp_low = bprq_pkg::low_bit(group_bits);
  assign row_low = bprq_pkg::low_bit(row_bits[grp_low]);

  // Response register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      removed_task  <= rem_task_q;
      removed_valid <= rem_ok_q;
      any_ready     <= |group_bits;
      highest_ready <= (|group_bits) ? {grp_low, row_low} : '0;
    end
  end

endmodule

/* rtl/core/bitmap_priority_ready_queue.sv */
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue
// Ready queue over up to 64 priorities with a FIFO of task ids per level.
// ----------------------------------------------------------------------------
// Each request beat either appends a task to its priority's chain or pops
// the head task of that priority, and yields exactly one response beat with
// the popped task, the most urgent ready priority and an any-ready flag.
// One request is in flight at a time. The response register is loaded
// after the execute state for an add or for a remove that empties its
// level or finds nothing, and after the execute and pop states for a
// remove that advances to a successor. The next request is taken once
// the response register has loaded, which waits while a stalled beat
// holds the register. The sequence is set by the registered read of the
// chain memories at accept and the dependent successor lookup on a
// remove. No clearing pass is needed after reset.
module bitmap_priority_ready_queue #(
  parameter int NUM_PRIOS    = 64,
  parameter int NUM_TASK_IDS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        kind,
  input  logic [bprq_pkg::PRIO_W-1:0] prio,
  input  logic [bprq_pkg::TASK_W-1:0] task_req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic [bprq_pkg::TASK_W-1:0] removed_task,
  output logic                        removed_valid,
  output logic [bprq_pkg::PRIO_W-1:0] highest_ready,
  output logic                        any_ready
);

  bprq_pkg::dp_cmd_t    cmd;
  bprq_pkg::dp_status_t status;

  // Sequencer.
  bprq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Storage and result logic.
  bprq_datapath #(
    .NUM_PRIOS    (NUM_PRIOS),
    .NUM_TASK_IDS (NUM_TASK_IDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .kind          (kind),
    .prio          (prio),
    .task_req      (task_req),
    .removed_task  (removed_task),
    .removed_valid (removed_valid),
    .highest_ready (highest_ready),
    .any_ready     (any_ready)
  );

endmodule

/* rtl/core/bprq_checker.sv */
// ----------------------------------------------------------------------------
// bprq_checker
// Port-level checks for the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
module bprq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic [bprq_pkg::TASK_W-1:0] removed_task,
  input logic                        removed_valid,
  input logic [bprq_pkg::PRIO_W-1:0] highest_ready,
  input logic                        any_ready
);

  // Only one request is worked on at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while another is in flight");

  // With nothing ready the reported priority is zero.
  a_idle_prio: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !any_ready |-> highest_ready == '0)
    else $error("highest_ready nonzero with nothing ready");

  // A response without a popped task reports task zero.
  a_no_pop_task: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !removed_valid |-> removed_task == '0)
    else $error("removed_task nonzero without a pop");

  // A stalled response beat holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(removed_task) &&
      $stable(removed_valid) && $stable(highest_ready) && $stable(any_ready))
    else $error("stalled response changed");

endmodule

bind bitmap_priority_ready_queue bprq_checker u_bprq_checker (.*);
